// ----- rtl/core/tcgr_pkg.sv -----
package tcgr_pkg;

   // default sizing, handed to the top level parameters
   localparam int GLYPH_ROWS_DEF    = 16;
   localparam int MAX_COLUMNS_DEF   = 128;
   localparam int MAX_TEXT_ROWS_DEF = 64;

   // store geometry
   localparam int CELL_DEPTH = 8192;
   localparam int CELL_AW    = 13;
   localparam int FONT_DEPTH = 4096;
   localparam int FONT_AW    = 12;
   localparam int PAL_DEPTH  = 16;
   localparam int PAL_AW     = 4;
   localparam int ADDR_W     = 24;
   localparam int STRIDE_W   = 14;
   localparam int COLS_W     = 8;
   localparam int PIX_W      = 32;
   localparam int CSR_AW     = 4;

   localparam logic [15:0] SPACE_CELL = 16'h0020;

   // request modes
   typedef enum logic [1:0] {
      MODE_CELL    = 2'd0,
      MODE_FORCE   = 2'd1,
      MODE_PALETTE = 2'd2,
      MODE_FONT    = 2'd3
   } mode_type;

   // register indexes
   localparam logic [1:0] REG_DEPTH   = 2'd0;
   localparam logic [1:0] REG_STRIDE  = 2'd1;
   localparam logic [1:0] REG_COLUMNS = 2'd2;

   // depth codes
   localparam logic [1:0] DEPTH_8  = 2'd0;
   localparam logic [1:0] DEPTH_16 = 2'd1;

   // register reset values
   localparam logic [1:0]          DEPTH_RST   = DEPTH_8;
   localparam logic [STRIDE_W-1:0] STRIDE_RST  = 14'd640;
   localparam logic [COLS_W-1:0]   COLUMNS_RST = 8'd80;

   typedef struct packed {
      logic [1:0]          depth_mode;
      logic [STRIDE_W-1:0] line_stride;
      logic [COLS_W-1:0]   text_columns;
   } cfg_type;

   function automatic logic [PIX_W-1:0] depth_mask(input logic [1:0] depth);
      logic [PIX_W-1:0] m;
      case (depth)
         DEPTH_8:  m = 32'h0000_00FF;
         DEPTH_16: m = 32'h0000_FFFF;
         default:  m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

// ----- rtl/core/tcgr_req_if.sv -----
interface tcgr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [6:0]  cell_col;
   logic [5:0]  cell_row;
   logic [15:0] cell_word;
   logic [11:0] table_index;
   logic [31:0] table_data;

   modport source (
      output valid, mode, cell_col, cell_row, cell_word, table_index, table_data,
      input  ready
   );
   modport sink (
      input  valid, mode, cell_col, cell_row, cell_word, table_index, table_data,
      output ready
   );
endinterface

// ----- rtl/core/tcgr_rsp_if.sv -----
interface tcgr_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] row_address;
   logic [31:0] pixel_0;
   logic [31:0] pixel_1;
   logic [31:0] pixel_2;
   logic [31:0] pixel_3;
   logic [31:0] pixel_4;
   logic [31:0] pixel_5;
   logic [31:0] pixel_6;
   logic [31:0] pixel_7;
   logic        last_row;

   modport source (
      output valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3,
             pixel_4, pixel_5, pixel_6, pixel_7, last_row,
      input  ready
   );
   modport sink (
      input  valid, row_address, pixel_0, pixel_1, pixel_2, pixel_3,
             pixel_4, pixel_5, pixel_6, pixel_7, last_row,
      output ready
   );
endinterface

// ----- rtl/core/tcgr_mac.sv -----
// Shared multiply-add unit: y = a*b + c, registered, modulo 2^24.
module tcgr_mac #(
   parameter int A_W = 10
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [A_W-1:0]                a,
   input  logic [tcgr_pkg::STRIDE_W-1:0] b,
   input  logic [tcgr_pkg::ADDR_W-1:0]   c,
   output logic [tcgr_pkg::ADDR_W-1:0]   y_ff
);

   localparam int P_W = A_W + tcgr_pkg::STRIDE_W;

   logic [P_W-1:0]                prod;
   logic [tcgr_pkg::ADDR_W-1:0]   y_in;

   assign prod = P_W'(a) * P_W'(b);
   assign y_in = tcgr_pkg::ADDR_W'(prod) + c;

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

endmodule

// ----- rtl/core/tcgr_csr.sv -----
// APB register block: depth, stride, columns.
module tcgr_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tcgr_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output tcgr_pkg::cfg_type           cfg
);

   tcgr_pkg::cfg_type cfg_ff;
   logic              wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode   <= tcgr_pkg::DEPTH_RST;
         cfg_ff.line_stride  <= tcgr_pkg::STRIDE_RST;
         cfg_ff.text_columns <= tcgr_pkg::COLUMNS_RST;
      end else if (wr_en) begin
         case (paddr[3:2])
            tcgr_pkg::REG_DEPTH:   cfg_ff.depth_mode   <= pwdata[1:0];
            tcgr_pkg::REG_STRIDE:  cfg_ff.line_stride  <= pwdata[tcgr_pkg::STRIDE_W-1:0];
            tcgr_pkg::REG_COLUMNS: cfg_ff.text_columns <= pwdata[tcgr_pkg::COLS_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (paddr[3:2])
         tcgr_pkg::REG_DEPTH:   prdata = 32'(cfg_ff.depth_mode);
         tcgr_pkg::REG_STRIDE:  prdata = 32'(cfg_ff.line_stride);
         tcgr_pkg::REG_COLUMNS: prdata = 32'(cfg_ff.text_columns);
         default:               prdata = 32'd0;
      endcase
   end

endmodule

// ----- rtl/core/text_cell_glyph_renderer_core.sv -----
// Channel   Dir  Handshake       Beat contents
// req_bus   in   valid/ready     mode, cell_col, cell_row, cell_word, table_index, table_data
// rsp_bus   out  valid/ready     row_address, pixel_0..pixel_7, last_row
// csr       in   APB, pready=1   depth_mode @0x0, line_stride @0x4, text_columns @0x8
//
// Palette and font writes land as the beat is taken; an off-screen cell is dropped; an
// unchanged cell passes lookup and compare. A redrawn cell goes on to bg and rows: one
// glyph row per cycle while rsp_bus is not stalled, set by the single font read port and
// the shared multiply-add unit. After reset the text store is swept to spaces: req_bus is
// not ready until all 8192 entries are cleared. A stalled rsp_bus holds the row pipeline;
// the block accepts the next beat once the last row has reached the output register.
module text_cell_glyph_renderer_core #(
   parameter int GLYPH_ROWS    = tcgr_pkg::GLYPH_ROWS_DEF,
   parameter int MAX_COLUMNS   = tcgr_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_TEXT_ROWS = tcgr_pkg::MAX_TEXT_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   tcgr_req_if.sink                    req_bus,
   tcgr_rsp_if.source                  rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tcgr_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int LINE_W = $clog2(MAX_TEXT_ROWS * GLYPH_ROWS);
   localparam int RCNT_W = $clog2(GLYPH_ROWS + 1);
   localparam int AW     = tcgr_pkg::ADDR_W;
   localparam int PW     = tcgr_pkg::PIX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMPARE,
      ST_BG,
      ST_ROWS
   } state_type;

   tcgr_pkg::cfg_type cfg;

   state_type                    state_ff;
   logic                         clearing_ff;
   logic [tcgr_pkg::CELL_AW-1:0] clr_addr_ff;
   logic [1:0]                   mode_ff;
   logic [6:0]                   col_ff;
   logic [5:0]                   row_ff;
   logic [15:0]                  word_ff;
   logic [tcgr_pkg::CELL_AW-1:0] idx_ff;
   logic [PW-1:0]                fg_ff;
   logic [PW-1:0]                bg_ff;
   logic [RCNT_W-1:0]            row_cnt_ff;
   logic                         s1_vld_ff;
   logic                         s1_last_ff;
   logic                         rsp_vld_ff;
   logic [AW-1:0]                rsp_addr_ff;
   logic [PW-1:0]                rsp_pix_ff [8];
   logic                         rsp_last_ff;

   // stores
   logic [15:0]                  cell_mem [tcgr_pkg::CELL_DEPTH];
   logic [15:0]                  cell_q_ff;
   logic [7:0]                   font_mem [tcgr_pkg::FONT_DEPTH];
   logic [7:0]                   font_q_ff;
   logic [PW-1:0]                pal_mem [tcgr_pkg::PAL_DEPTH];
   logic [tcgr_pkg::PAL_DEPTH-1:0] pal_vld_ff;
   logic [PW-1:0]                pal_q_ff;
   logic                         pal_rv_ff;
   logic [tcgr_pkg::PAL_AW-1:0]  pal_ra_ff;

   logic                         req_fire;
   logic                         in_bounds;
   logic                         cell_req;
   logic                         advance;
   logic                         issue;
   logic                         cell_we;
   logic                         same_word;
   logic [tcgr_pkg::PAL_AW-1:0]  pal_raddr;
   logic [PW-1:0]                pal_val;
   logic [PW-1:0]                mask;
   logic [LINE_W-1:0]            line;
   logic                         mac_en;
   logic [LINE_W-1:0]            mac_a;
   logic [tcgr_pkg::STRIDE_W-1:0] mac_b;
   logic [AW-1:0]                mac_c;
   logic [AW-1:0]                mac_y;

   tcgr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake and decode
   assign req_bus.ready = (state_ff == ST_IDLE) && !clearing_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign in_bounds     = ({1'b0, req_bus.cell_col} < cfg.text_columns)
                       && ({1'b0, req_bus.cell_col} < 8'(MAX_COLUMNS))
                       && ({1'b0, req_bus.cell_row} < 7'(MAX_TEXT_ROWS));
   assign cell_req      = req_fire && in_bounds
                       && ((req_bus.mode == tcgr_pkg::MODE_CELL)
                        || (req_bus.mode == tcgr_pkg::MODE_FORCE));

   // row pipeline moves when the output register is free or being taken
   assign advance = !rsp_vld_ff || rsp_bus.ready;
   assign issue   = (state_ff == ST_ROWS) && advance
                 && (row_cnt_ff < RCNT_W'(GLYPH_ROWS));

   assign same_word = (mode_ff == tcgr_pkg::MODE_CELL) && (cell_q_ff == word_ff);
   assign cell_we   = (state_ff == ST_COMPARE) && !same_word;
   assign mask      = tcgr_pkg::depth_mask(cfg.depth_mode);

   // shared multiply-add: cell index at accept, row address per glyph row
   assign line   = LINE_W'(int'(row_ff) * GLYPH_ROWS) + LINE_W'(row_cnt_ff);
   assign mac_en = cell_req || issue;
   always_comb begin
      if (state_ff == ST_ROWS) begin
         mac_a = line;
         mac_b = cfg.line_stride;
         mac_c = AW'({col_ff, 3'b000});
      end else begin
         mac_a = LINE_W'(req_bus.cell_row);
         mac_b = tcgr_pkg::STRIDE_W'(cfg.text_columns);
         mac_c = AW'(req_bus.cell_col);
      end
   end

   tcgr_mac #(.A_W(LINE_W)) u_mac (
      .clock (clock),
      .en    (mac_en),
      .a     (mac_a),
      .b     (mac_b),
      .c     (mac_c),
      .y_ff  (mac_y)
   );

   // text cell store: sweep after reset, one port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         cell_mem[clr_addr_ff] <= tcgr_pkg::SPACE_CELL;
      end else if (cell_we) begin
         cell_mem[idx_ff] <= word_ff;
      end
      if (state_ff == ST_LOOKUP) begin
         cell_q_ff <= cell_mem[mac_y[tcgr_pkg::CELL_AW-1:0]];
      end
   end

   // font store
   always_ff @(posedge clock) begin
      if (req_fire && (req_bus.mode == tcgr_pkg::MODE_FONT)) begin
         font_mem[req_bus.table_index] <= req_bus.table_data[7:0];
      end
      if (issue) begin
         font_q_ff <= font_mem[{word_ff[7:0], 4'(row_cnt_ff)}];
      end
   end

   // palette: fg read in lookup, bg read in compare
   assign pal_raddr = (state_ff == ST_LOOKUP) ? word_ff[11:8] : word_ff[15:12];
   assign pal_val   = pal_rv_ff ? pal_q_ff : PW'(pal_ra_ff);

   always_ff @(posedge clock) begin
      if (req_fire && (req_bus.mode == tcgr_pkg::MODE_PALETTE)
          && (req_bus.table_index < 12'(tcgr_pkg::PAL_DEPTH))) begin
         pal_mem[req_bus.table_index[tcgr_pkg::PAL_AW-1:0]] <= req_bus.table_data;
      end
      pal_q_ff  <= pal_mem[pal_raddr];
      pal_ra_ff <= pal_raddr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
      end else begin
         if (req_fire && (req_bus.mode == tcgr_pkg::MODE_PALETTE)
             && (req_bus.table_index < 12'(tcgr_pkg::PAL_DEPTH))) begin
            pal_vld_ff[req_bus.table_index[tcgr_pkg::PAL_AW-1:0]] <= 1'b1;
         end
         pal_rv_ff <= pal_vld_ff[pal_raddr];
      end
   end

   // sequencer, row pipeline and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         row_cnt_ff  <= '0;
         s1_vld_ff   <= 1'b0;
         s1_last_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == tcgr_pkg::CELL_AW'(tcgr_pkg::CELL_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (cell_req) begin
                  mode_ff  <= req_bus.mode;
                  col_ff   <= req_bus.cell_col;
                  row_ff   <= req_bus.cell_row;
                  word_ff  <= req_bus.cell_word;
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               idx_ff   <= mac_y[tcgr_pkg::CELL_AW-1:0];
               state_ff <= ST_COMPARE;
            end
            ST_COMPARE: begin
               fg_ff <= pal_val & mask;
               if (same_word) begin
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_BG;
               end
            end
            ST_BG: begin
               bg_ff      <= pal_val & mask;
               row_cnt_ff <= '0;
               state_ff   <= ST_ROWS;
            end
            ST_ROWS: begin
               if (issue) begin
                  row_cnt_ff <= row_cnt_ff + 1'b1;
               end
               if ((row_cnt_ff == RCNT_W'(GLYPH_ROWS)) && !s1_vld_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // fetch stage: font row and address land here
         if (advance) begin
            s1_vld_ff  <= issue;
            s1_last_ff <= issue && (row_cnt_ff == RCNT_W'(GLYPH_ROWS - 1));
            rsp_vld_ff <= s1_vld_ff;
            if (s1_vld_ff) begin
               rsp_addr_ff <= mac_y;
               rsp_last_ff <= s1_last_ff;
               for (int j = 0; j < 8; j++) begin
                  rsp_pix_ff[j] <= font_q_ff[7-j] ? fg_ff : bg_ff;
               end
            end
         end
      end
   end

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.row_address = rsp_addr_ff;
   assign rsp_bus.pixel_0     = rsp_pix_ff[0];
   assign rsp_bus.pixel_1     = rsp_pix_ff[1];
   assign rsp_bus.pixel_2     = rsp_pix_ff[2];
   assign rsp_bus.pixel_3     = rsp_pix_ff[3];
   assign rsp_bus.pixel_4     = rsp_pix_ff[4];
   assign rsp_bus.pixel_5     = rsp_pix_ff[5];
   assign rsp_bus.pixel_6     = rsp_pix_ff[6];
   assign rsp_bus.pixel_7     = rsp_pix_ff[7];
   assign rsp_bus.last_row    = rsp_last_ff;

endmodule

// ----- rtl/core/tcgr_chk.sv -----
// Port-level checks on the renderer.
module tcgr_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_row_address,
   input logic        rsp_last_row
);

   // store sweep keeps the input closed right after reset
   a_sweep_closed: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input open during store sweep");

   // more rows of the same cell still owed: no new beat taken
   a_busy_mid_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_row) |=> !req_ready)
      else $error("input open while a cell is still being drawn");

   // stalled result stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   // stalled result keeps its address
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_row_address))
      else $error("result address changed while stalled");

endmodule

bind text_cell_glyph_renderer_core tcgr_chk u_tcgr_chk (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_row_address (rsp_bus.row_address),
   .rsp_last_row    (rsp_bus.last_row)
);

// ----- tb/text_cell_glyph_renderer_core_tb.sv -----
module text_cell_glyph_renderer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GLYPH_ROWS   = tcgr_pkg::GLYPH_ROWS_DEF;
   localparam int GLYPH_SLOTS  = 16;
   localparam int DRAIN_CYCLES = 2 * GLYPH_ROWS + 8;
   localparam int CYCLE_LIMIT  = 400_000;
   localparam int PRINT_LIMIT  = 40;

   // depth codes beyond the two the package names
   localparam logic [1:0] DEPTH_32     = 2'd2;
   localparam logic [1:0] DEPTH_32_ALT = 2'd3;

   typedef struct packed {
      tcgr_pkg::mode_type mode;
      logic [6:0]         cell_col;
      logic [5:0]         cell_row;
      logic [15:0]        cell_word;
      logic [11:0]        table_index;
      logic [31:0]        table_data;
   } request_type;

   typedef struct packed {
      logic [tcgr_pkg::ADDR_W-1:0]     row_address;
      logic [7:0][tcgr_pkg::PIX_W-1:0] pixel;
      logic                            last_row;
   } glyph_row_type;

   // shadow of the renderer plus the queue of glyph rows still owed
   class render_board;
      logic [1:0]                    depth_mode;
      logic [tcgr_pkg::STRIDE_W-1:0] line_stride;
      logic [tcgr_pkg::COLS_W-1:0]   text_columns;
      logic [15:0]                   cell_store [tcgr_pkg::CELL_DEPTH];
      logic [tcgr_pkg::PIX_W-1:0]    palette [tcgr_pkg::PAL_DEPTH];
      logic [7:0]                    font_rows [tcgr_pkg::FONT_DEPTH];
      glyph_row_type                 rows_due [$];
      int                            mismatches;
      int                            rows_checked;
      int                            cells_drawn;

      function new();
         depth_mode   = tcgr_pkg::DEPTH_RST;
         line_stride  = tcgr_pkg::STRIDE_RST;
         text_columns = tcgr_pkg::COLUMNS_RST;
         foreach (cell_store[i]) cell_store[i] = tcgr_pkg::SPACE_CELL;
         foreach (palette[i]) palette[i] = tcgr_pkg::PIX_W'(i);
         foreach (font_rows[i]) font_rows[i] = 8'h00;
         mismatches   = 0;
         rows_checked = 0;
         cells_drawn  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            tcgr_pkg::REG_DEPTH:   depth_mode   = value[1:0];
            tcgr_pkg::REG_STRIDE:  line_stride  = value[tcgr_pkg::STRIDE_W-1:0];
            tcgr_pkg::REG_COLUMNS: text_columns = value[tcgr_pkg::COLS_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [1:0] idx);
         case (idx)
            tcgr_pkg::REG_DEPTH:   return 32'(depth_mode);
            tcgr_pkg::REG_STRIDE:  return 32'(line_stride);
            tcgr_pkg::REG_COLUMNS: return 32'(text_columns);
            default:               return 32'h0;
         endcase
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
      endfunction

      // update the tables and queue the rows a redrawn cell owes
      function void note_request(request_type r);
         logic [12:0]                slot;
         logic [tcgr_pkg::PIX_W-1:0] mask;
         logic [tcgr_pkg::PIX_W-1:0] ink;
         logic [tcgr_pkg::PIX_W-1:0] paper;
         logic [7:0]                 glyph;
         logic [31:0]                addr;
         int                         line_no;
         glyph_row_type              row;
         if (r.mode == tcgr_pkg::MODE_PALETTE) begin
            // indexes past the palette are dropped
            if (int'(r.table_index) < tcgr_pkg::PAL_DEPTH)
               palette[r.table_index[tcgr_pkg::PAL_AW-1:0]] = r.table_data;
            return;
         end
         if (r.mode == tcgr_pkg::MODE_FONT) begin
            font_rows[r.table_index] = r.table_data[7:0];
            return;
         end
         // cell off the screen: nothing stored, nothing drawn
         if (int'(r.cell_col) >= int'(text_columns) ||
             int'(r.cell_col) >= tcgr_pkg::MAX_COLUMNS_DEF ||
             int'(r.cell_row) >= tcgr_pkg::MAX_TEXT_ROWS_DEF)
            return;
         slot = 13'(int'(r.cell_row) * int'(text_columns) + int'(r.cell_col));
         if (r.mode == tcgr_pkg::MODE_CELL && cell_store[slot] == r.cell_word) return;
         cell_store[slot] = r.cell_word;
         cells_drawn++;
         // selector three falls through to full 32-bit pixels
         mask  = (depth_mode == tcgr_pkg::DEPTH_8) ? 32'h0000_00FF :
                 (depth_mode == tcgr_pkg::DEPTH_16) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
         ink   = palette[r.cell_word[11:8]] & mask;
         paper = palette[r.cell_word[15:12]] & mask;
         for (int i = 0; i < GLYPH_ROWS; i++) begin
            glyph   = font_rows[{r.cell_word[7:0], 4'(i)}];
            line_no = int'(r.cell_row) * GLYPH_ROWS + i;
            addr    = 32'(line_no) * 32'(line_stride) + 32'(r.cell_col) * 32'd8;
            row.row_address = addr[tcgr_pkg::ADDR_W-1:0];
            for (int j = 0; j < 8; j++) row.pixel[j] = glyph[7-j] ? ink : paper;
            row.last_row = (i == GLYPH_ROWS - 1);
            rows_due.push_back(row);
         end
      endfunction

      function void check_row(glyph_row_type got);
         glyph_row_type want;
         if (rows_due.size() == 0) begin
            flag("no row pending, row_address", 32'h0, 32'(got.row_address));
            return;
         end
         want = rows_due.pop_front();
         rows_checked++;
         if (got.row_address !== want.row_address)
            flag("row_address", 32'(want.row_address), 32'(got.row_address));
         for (int j = 0; j < 8; j++)
            if (got.pixel[j] !== want.pixel[j])
               flag($sformatf("pixel_%0d", j), want.pixel[j], got.pixel[j]);
         if (got.last_row !== want.last_row)
            flag("last_row", 32'(want.last_row), 32'(got.last_row));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [tcgr_pkg::CSR_AW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tcgr_req_if req_bus();
   tcgr_rsp_if rsp_bus();

   text_cell_glyph_renderer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   render_board board;
   logic [7:0]  glyph_chars [$];
   bit          glyph_ready [256];
   int          gap_pct;
   int          stall_pct;
   int          beats_sent;
   int          settings_run;
   int          cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout: run still busy after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
   end

   // beat monitors
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         board.note_request('{mode: tcgr_pkg::mode_type'(req_bus.mode),
                              cell_col: req_bus.cell_col,
                              cell_row: req_bus.cell_row, cell_word: req_bus.cell_word,
                              table_index: req_bus.table_index,
                              table_data: req_bus.table_data});
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_row('{row_address: rsp_bus.row_address,
                           pixel: {rsp_bus.pixel_7, rsp_bus.pixel_6, rsp_bus.pixel_5,
                                   rsp_bus.pixel_4, rsp_bus.pixel_3, rsp_bus.pixel_2,
                                   rsp_bus.pixel_1, rsp_bus.pixel_0},
                           last_row: rsp_bus.last_row});
   end

   // result side back-pressure in bursts
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 99) < stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 15) - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic request_type noise_beat();
      request_type r;
      r.mode        = tcgr_pkg::mode_type'($urandom_range(0, 3));
      r.cell_col    = 7'($urandom);
      r.cell_row    = 6'($urandom);
      r.cell_word   = 16'($urandom);
      r.table_index = 12'($urandom);
      r.table_data  = $urandom;
      return r;
   endfunction

   function automatic request_type cell_beat(tcgr_pkg::mode_type mode, int col, int row,
                                             logic [15:0] word);
      request_type r;
      r           = noise_beat();
      r.mode      = mode;
      r.cell_col  = 7'(col);
      r.cell_row  = 6'(row);
      r.cell_word = word;
      return r;
   endfunction

   function automatic request_type table_beat(tcgr_pkg::mode_type mode, logic [11:0] idx,
                                              logic [31:0] data);
      request_type r;
      r             = noise_beat();
      r.mode        = mode;
      r.table_index = idx;
      r.table_data  = data;
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_req(input request_type r);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= r.mode;
      req_bus.cell_col    <= r.cell_col;
      req_bus.cell_row    <= r.cell_row;
      req_bus.cell_word   <= r.cell_word;
      req_bus.table_index <= r.table_index;
      req_bus.table_data  <= r.table_data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   // hold off until every owed row is back and the block has gone quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // write then read back one register; block must be idle
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_reg(idx, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== board.reg_value(idx))
         board.flag($sformatf("register %0d readback", idx), board.reg_value(idx), readback);
      // bus left idle between transfers
      @(negedge clock);
   endtask

   // all sixteen row slots of one character, so draws never hit unwritten font
   task automatic load_glyph(input logic [7:0] ch);
      logic [31:0] bits;
      for (int i = 0; i < GLYPH_SLOTS; i++) begin
         bits = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'h0 : $urandom;
         send_req(table_beat(tcgr_pkg::MODE_FONT, {ch, 4'(i)}, bits));
      end
      if (!glyph_ready[ch]) glyph_chars.push_back(ch);
      glyph_ready[ch] = 1'b1;
   endtask

   task automatic random_step(inout int counted);
      request_type r;
      logic [7:0]  ch;
      logic [12:0] slot;
      int          pick;
      int          span;
      r    = noise_beat();
      pick = $urandom_range(0, 99);
      span = (int'(board.text_columns) > tcgr_pkg::MAX_COLUMNS_DEF)
             ? tcgr_pkg::MAX_COLUMNS_DEF : int'(board.text_columns);
      if (pick < 5 && glyph_chars.size() < 40) begin
         do ch = 8'($urandom); while (glyph_ready[ch]);
         load_glyph(ch);
         counted += GLYPH_SLOTS;
         return;
      end
      if (pick < 12) begin
         r.mode = tcgr_pkg::MODE_PALETTE;
         if ($urandom_range(0, 3) != 0)
            r.table_index = 12'($urandom_range(0, tcgr_pkg::PAL_DEPTH - 1));
         counted++;
      end else if (pick < 16) begin
         // stray font row anywhere in the table
         r.mode = tcgr_pkg::MODE_FONT;
         counted++;
      end else if ((pick < 26 || span == 0) && span < tcgr_pkg::MAX_COLUMNS_DEF) begin
         r.mode     = $urandom_range(0, 1) ? tcgr_pkg::MODE_FORCE : tcgr_pkg::MODE_CELL;
         r.cell_col = 7'($urandom_range(int'(board.text_columns),
                                        tcgr_pkg::MAX_COLUMNS_DEF - 1));
      end else begin
         r.cell_col = 7'($urandom_range(0, span - 1));
         slot = 13'(int'(r.cell_row) * int'(board.text_columns) + int'(r.cell_col));
         if (pick < 36) begin
            // rewrite of what is already there
            r.mode      = tcgr_pkg::MODE_CELL;
            r.cell_word = board.cell_store[slot];
         end else begin
            r.mode      = ($urandom_range(0, 4) == 0) ? tcgr_pkg::MODE_FORCE
                                                      : tcgr_pkg::MODE_CELL;
            r.cell_word = {4'($urandom), 4'($urandom),
                           glyph_chars[$urandom_range(0, glyph_chars.size() - 1)]};
            if (r.mode == tcgr_pkg::MODE_FORCE || r.cell_word != board.cell_store[slot])
               counted++;
         end
      end
      send_req(r);
      if ($urandom_range(0, 39) == 0) settle();
   endtask

   task automatic run_phase(input logic [1:0] depth, input int stride, input int cols,
                            input int idle, input int quota);
      int counted;
      counted = 0;
      write_reg(tcgr_pkg::REG_DEPTH, {30'($urandom), depth});
      write_reg(tcgr_pkg::REG_STRIDE, {18'($urandom), 14'(stride)});
      write_reg(tcgr_pkg::REG_COLUMNS, {24'($urandom), 8'(cols)});
      gap_pct   = idle;
      stall_pct = idle;
      settings_run++;
      while (counted < quota) random_step(counted);
      settle();
   endtask

   initial begin
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = 32'h0;
      req_bus.valid       = 1'b0;
      req_bus.mode        = tcgr_pkg::MODE_CELL;
      req_bus.cell_col    = 7'h0;
      req_bus.cell_row    = 6'h0;
      req_bus.cell_word   = 16'h0;
      req_bus.table_index = 12'h0;
      req_bus.table_data  = 32'h0;
      gap_pct             = 6;
      stall_pct           = 6;
      beats_sent          = 0;
      settings_run        = 1;
      board               = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset register values, two full glyphs to draw with
      load_glyph(8'h00);
      load_glyph(8'hFF);
      send_req(table_beat(tcgr_pkg::MODE_PALETTE, 12'd0, 32'hFFFF_FFFF));
      send_req(table_beat(tcgr_pkg::MODE_PALETTE, 12'd15, 32'hA5C3_0F96));
      send_req(table_beat(tcgr_pkg::MODE_PALETTE, 12'd16, 32'h0BAD_0BAD));  // past palette
      send_req(table_beat(tcgr_pkg::MODE_PALETTE, 12'hFFF, 32'h0));
      send_req(cell_beat(tcgr_pkg::MODE_CELL, 0, 0, 16'hF0FF));
      send_req(cell_beat(tcgr_pkg::MODE_CELL, 0, 0, 16'hF0FF));       // same word, no draw
      send_req(cell_beat(tcgr_pkg::MODE_FORCE, 0, 0, 16'hF0FF));      // forced redraw
      send_req(cell_beat(tcgr_pkg::MODE_CELL, 79, 63, 16'h0F00));
      send_req(cell_beat(tcgr_pkg::MODE_CELL, 80, 5, 16'h1100));      // just off screen
      send_req(cell_beat(tcgr_pkg::MODE_FORCE, 127, 63, 16'hFFFF));   // far off screen
      send_req(cell_beat(tcgr_pkg::MODE_CELL, 3, 2, tcgr_pkg::SPACE_CELL)); // reset fill
      send_req(cell_beat(tcgr_pkg::MODE_CELL, 40, 31, 16'hFFFF));
      send_req(table_beat(tcgr_pkg::MODE_FONT, 12'hFFF, 32'hFFFF_FF3C)); // low byte kept
      send_req(cell_beat(tcgr_pkg::MODE_FORCE, 40, 31, 16'hFFFF));
      send_req(cell_beat(tcgr_pkg::MODE_FORCE, 1, 0, 16'h5A00));
      settle();

      // register settings, extremes first; the last one runs with no idling
      run_phase(tcgr_pkg::DEPTH_16, 1, tcgr_pkg::MAX_COLUMNS_DEF, 8, 22);
      run_phase(DEPTH_32, 16383, 1, 10, 22);
      run_phase(DEPTH_32_ALT, 0, 255, 0, 20);   // zero stride, wrapped cell index
      run_phase(tcgr_pkg::DEPTH_8, 8192, 0, 8, 10);   // no column in use
      run_phase(2'($urandom_range(0, 3)), $urandom_range(1, 8192), $urandom_range(1, 128),
                12, 22);
      run_phase(DEPTH_32, 7, 37, 0, 20);

      $display("covered %0d request beats over %0d register settings", beats_sent,
               settings_run);
      $display("%0d cells redrawn, %0d glyph rows checked, %0d mismatches",
               board.cells_drawn, board.rows_checked, board.mismatches);
      if (board.mismatches == 0 && board.rows_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_req_if.sv
rtl/core/tcgr_rsp_if.sv
rtl/core/tcgr_mac.sv
rtl/core/tcgr_csr.sv
rtl/core/text_cell_glyph_renderer_core.sv
rtl/core/tcgr_chk.sv
tb/text_cell_glyph_renderer_core_tb.sv
